FILE: src/ppam_pkg.sv
package ppam_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned GAP_W    = 8;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 120;

    localparam logic [CNT_W-1:0] SAT16 = 16'hFFFF;

    localparam logic [1:0] REQ_PEDAL = 2'd0;
    localparam logic [1:0] REQ_WHEEL = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_MIN_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MIN_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_TIMEOUT = 2'd3;

    localparam logic [GAP_W-1:0] RST_PEDAL_MIN_GAP = 8'd64;
    localparam logic [GAP_W-1:0] RST_WHEEL_MIN_GAP = 8'd100;
    localparam logic [TMO_W-1:0] RST_PEDAL_TIMEOUT = 16'd500;
    localparam logic [TMO_W-1:0] RST_WHEEL_TIMEOUT = 16'd3000;

    typedef struct packed {
        logic [GAP_W-1:0] pedal_min_gap;
        logic [GAP_W-1:0] wheel_min_gap;
        logic [TMO_W-1:0] pedal_timeout;
        logic [TMO_W-1:0] wheel_timeout;
    } t_cfg;

    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] count;
    } t_chan_rpt;

endpackage

FILE: src/ppam_cfg_regs.sv
module ppam_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppam_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output ppam_pkg::t_cfg                 o_cfg
);
    import ppam_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pedal_min_gap <= RST_PEDAL_MIN_GAP;
            r_cfg.wheel_min_gap <= RST_WHEEL_MIN_GAP;
            r_cfg.pedal_timeout <= RST_PEDAL_TIMEOUT;
            r_cfg.wheel_timeout <= RST_WHEEL_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PEDAL_MIN_GAP: r_cfg.pedal_min_gap <= i_cfg_data[GAP_W-1:0];
                CFG_WHEEL_MIN_GAP: r_cfg.wheel_min_gap <= i_cfg_data[GAP_W-1:0];
                CFG_PEDAL_TIMEOUT: r_cfg.pedal_timeout <= i_cfg_data[TMO_W-1:0];
                CFG_WHEEL_TIMEOUT: r_cfg.wheel_timeout <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/ppam_chan.sv
module ppam_chan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pulse,
    input  logic                        i_tick,
    input  logic [ppam_pkg::TIME_W-1:0] i_now,
    input  logic [ppam_pkg::GAP_W-1:0]  i_min_gap,
    input  logic [ppam_pkg::TMO_W-1:0]  i_timeout,
    output ppam_pkg::t_chan_rpt         o_rpt
);
    import ppam_pkg::*;

    logic [TIME_W-1:0] r_last_time;
    logic [CNT_W-1:0]  r_period;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_run;

    logic [TIME_W-1:0] gap;
    logic              take;
    logic              active;
    logic [CNT_W-1:0]  sat_period;
    logic [CNT_W-1:0]  n_run;

    // spacing wraps modulo 2^32
    assign gap        = i_now - r_last_time;
    assign take       = gap >= {{(TIME_W-GAP_W){1'b0}}, i_min_gap};
    assign active     = gap < {{(TIME_W-TMO_W){1'b0}}, i_timeout};
    assign sat_period = (|gap[TIME_W-1:CNT_W]) ? SAT16 : gap[CNT_W-1:0];

    always_comb begin
        if (!active) begin
            n_run = '0;
        end else if (r_run == SAT16) begin
            n_run = r_run;
        end else begin
            n_run = r_run + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_period    <= '0;
            r_count     <= '0;
            r_run       <= '0;
        end else if (i_pulse && take) begin
            r_period    <= sat_period;
            r_last_time <= i_now;
            r_count     <= r_count + 1'b1;
        end else if (i_tick) begin
            r_run <= n_run;
            if (!active) begin
                r_period <= '0;
            end
        end
    end

    // values as they stand after this tick
    assign o_rpt.active = active;
    assign o_rpt.period = active ? r_period : '0;
    assign o_rpt.run    = n_run;
    assign o_rpt.count  = r_count;

endmodule

FILE: src/pulse_period_activity_monitor_unit.sv
// Pulse period and activity monitor. Each input beat carries a request kind in
// s_axis_tuser (pedal edge, wheel edge, sample tick) and a timestamp with the two
// brake pin levels in s_axis_tdata. One beat is accepted per clock: a beat is held in
// the input register, is evaluated against the channel state and, for a tick, lands
// in the result register; pulse edges produce no output beat. The input stalls only
// while a tick is waiting for a result register that is still held by the downstream
// side.
// Configuration writes are always taken and should only be issued while idle.
module pulse_period_activity_monitor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_ms, brake_left_pin, brake_right_pin, zero pad
    input  logic [ppam_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pedal_period_ms, wheel_period_ms, pedaling, moving, pedal_run_ticks,
    // moving_run_ticks, pedal_pulse_total, wheel_pulse_total, tick_total,
    // brake_left_on, brake_right_on, zero pad
    output logic [ppam_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppam_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import ppam_pkg::*;

    t_cfg      cfg;
    t_chan_rpt pedal_rpt;
    t_chan_rpt wheel_rpt;

    logic              r_in_valid;
    logic [1:0]        r_in_req;
    logic [TIME_W-1:0] r_in_now;
    logic              r_in_left;
    logic              r_in_right;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [CNT_W-1:0]      r_tick_cnt;
    logic [CNT_W-1:0]      n_tick_cnt;

    logic is_pedal;
    logic is_wheel;
    logic is_tick;
    logic adv;
    logic in_take;

    always_comb begin
        is_pedal = 1'b0;
        is_wheel = 1'b0;
        is_tick  = 1'b0;
        unique case (r_in_req)
            REQ_PEDAL: is_pedal = 1'b1;
            REQ_WHEEL: is_wheel = 1'b1;
            REQ_TICK:  is_tick  = 1'b1;
            default: begin
            end
        endcase
    end

    assign adv           = r_in_valid && (!is_tick || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign n_tick_cnt    = r_tick_cnt + 1'b1;

    ppam_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ppam_chan u_pedal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pulse   (adv && is_pedal),
        .i_tick    (adv && is_tick),
        .i_now     (r_in_now),
        .i_min_gap (cfg.pedal_min_gap),
        .i_timeout (cfg.pedal_timeout),
        .o_rpt     (pedal_rpt)
    );

    ppam_chan u_wheel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pulse   (adv && is_wheel),
        .i_tick    (adv && is_tick),
        .i_now     (r_in_now),
        .i_min_gap (cfg.wheel_min_gap),
        .i_timeout (cfg.wheel_timeout),
        .o_rpt     (wheel_rpt)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req   <= s_axis_tuser;
            r_in_now   <= s_axis_tdata[TIME_W-1:0];
            r_in_left  <= s_axis_tdata[TIME_W];
            r_in_right <= s_axis_tdata[TIME_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt <= '0;
        end else if (adv && is_tick) begin
            r_tick_cnt <= n_tick_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_tick) begin
            r_out_data <= {4'b0000, !r_in_right, !r_in_left, n_tick_cnt,
                           wheel_rpt.count, pedal_rpt.count, wheel_rpt.run, pedal_rpt.run,
                           wheel_rpt.active, pedal_rpt.active,
                           wheel_rpt.period, pedal_rpt.period};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ppam_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int WATCHDOG = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE = 8;
    localparam int SAT_LOOPS = 16;

    typedef struct {
        logic [1:0]        req;
        logic [TIME_W-1:0] now;
        logic              left_pin;
        logic              right_pin;
    } t_event;

    // lowest field last
    typedef struct packed {
        logic [3:0]       pad;
        logic             brake_right_on;
        logic             brake_left_on;
        logic [CNT_W-1:0] tick_total;
        logic [CNT_W-1:0] wheel_pulse_total;
        logic [CNT_W-1:0] pedal_pulse_total;
        logic [CNT_W-1:0] moving_run_ticks;
        logic [CNT_W-1:0] pedal_run_ticks;
        logic             moving;
        logic             pedaling;
        logic [CNT_W-1:0] wheel_period_ms;
        logic [CNT_W-1:0] pedal_period_ms;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = REQ_PEDAL;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PEDAL_MIN_GAP;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;

    t_event  pending_q[$];
    t_report report_q[$];

    t_cfg cfg = '{RST_PEDAL_MIN_GAP, RST_WHEEL_MIN_GAP, RST_PEDAL_TIMEOUT, RST_WHEEL_TIMEOUT};
    logic [TIME_W-1:0] pedal_last = '0;
    logic [TIME_W-1:0] wheel_last = '0;
    logic [CNT_W-1:0]  pedal_period = '0;
    logic [CNT_W-1:0]  wheel_period = '0;
    logic [CNT_W-1:0]  pedal_count = '0;
    logic [CNT_W-1:0]  wheel_count = '0;
    logic [CNT_W-1:0]  tick_count = '0;
    logic [CNT_W-1:0]  pedal_run = '0;
    logic [CNT_W-1:0]  moving_run = '0;

    int                fails = 0;
    int                quiet = 0;
    int                hold_cnt = 0;
    bit                in_took = 1'b0;
    bit                calm = 1'b0;
    bit                hold_go = 1'b0;
    logic [TIME_W-1:0] stamp = '0;

    pulse_period_activity_monitor_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic take_edge(input logic [TIME_W-1:0] now, input logic [GAP_W-1:0] min_gap,
                             inout logic [TIME_W-1:0] last, inout logic [CNT_W-1:0] period,
                             inout logic [CNT_W-1:0] count);
        logic [TIME_W-1:0] gap;
        gap = now - last;
        if (gap >= {24'b0, min_gap}) begin
            period = (gap > 32'h0000_FFFF) ? SAT16 : gap[CNT_W-1:0];
            last = now;
            count = count + 1'b1;
        end
    endtask

    task automatic predict(input logic [1:0] req, input logic [TIME_W-1:0] now,
                           input logic left_pin, input logic right_pin);
        t_report rep;
        logic    pedaling;
        logic    moving;
        case (req)
            REQ_PEDAL: take_edge(now, cfg.pedal_min_gap, pedal_last, pedal_period, pedal_count);
            REQ_WHEEL: take_edge(now, cfg.wheel_min_gap, wheel_last, wheel_period, wheel_count);
            REQ_TICK: begin
                tick_count = tick_count + 1'b1;
                if (pedal_run != SAT16) pedal_run = pedal_run + 1'b1;
                if (moving_run != SAT16) moving_run = moving_run + 1'b1;
                pedaling = (now - pedal_last) < {16'b0, cfg.pedal_timeout};
                moving = (now - wheel_last) < {16'b0, cfg.wheel_timeout};
                if (!pedaling) begin
                    pedal_run = '0;
                    pedal_period = '0;
                end
                if (!moving) begin
                    moving_run = '0;
                    wheel_period = '0;
                end
                rep = '0;
                rep.pedal_period_ms = pedal_period;
                rep.wheel_period_ms = wheel_period;
                rep.pedaling = pedaling;
                rep.moving = moving;
                rep.pedal_run_ticks = pedal_run;
                rep.moving_run_ticks = moving_run;
                rep.pedal_pulse_total = pedal_count;
                rep.wheel_pulse_total = wheel_count;
                rep.tick_total = tick_count;
                rep.brake_left_on = ~left_pin;
                rep.brake_right_on = ~right_pin;
                report_q.push_back(rep);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_report(input t_report got);
        t_report want;
        if (report_q.size() == 0) begin
            $error("result beat with nothing expected");
            fails++;
        end else begin
            want = report_q.pop_front();
            check_field("pedal_period_ms", want.pedal_period_ms, got.pedal_period_ms);
            check_field("wheel_period_ms", want.wheel_period_ms, got.wheel_period_ms);
            check_field("pedaling", want.pedaling, got.pedaling);
            check_field("moving", want.moving, got.moving);
            check_field("pedal_run_ticks", want.pedal_run_ticks, got.pedal_run_ticks);
            check_field("moving_run_ticks", want.moving_run_ticks, got.moving_run_ticks);
            check_field("pedal_pulse_total", want.pedal_pulse_total, got.pedal_pulse_total);
            check_field("wheel_pulse_total", want.wheel_pulse_total, got.wheel_pulse_total);
            check_field("tick_total", want.tick_total, got.tick_total);
            check_field("brake_left_on", want.brake_left_on, got.brake_left_on);
            check_field("brake_right_on", want.brake_right_on, got.brake_right_on);
        end
    endtask

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_took = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) check_report(t_report'(m_axis_tdata));
            if (in_took) predict(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[32],
                                 s_axis_tdata[33]);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PEDAL_MIN_GAP: cfg.pedal_min_gap = i_cfg_data[GAP_W-1:0];
                    CFG_WHEEL_MIN_GAP: cfg.wheel_min_gap = i_cfg_data[GAP_W-1:0];
                    CFG_PEDAL_TIMEOUT: cfg.pedal_timeout = i_cfg_data[TMO_W-1:0];
                    CFG_WHEEL_TIMEOUT: cfg.wheel_timeout = i_cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (in_took || (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_took)) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_q[0].req;
                s_axis_tdata <= {6'b0, pending_q[0].right_pin, pending_q[0].left_pin,
                                 pending_q[0].now};
                void'(pending_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    task automatic offer(input logic [1:0] req, input logic [TIME_W-1:0] now);
        pending_q.push_back('{req, now, 1'($urandom_range(1)), 1'($urandom_range(1))});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_limits(input logic [GAP_W-1:0] pmin, input logic [GAP_W-1:0] wmin,
                              input logic [TMO_W-1:0] ptmo, input logic [TMO_W-1:0] wtmo);
        write_reg(CFG_WHEEL_TIMEOUT, wtmo);
        write_reg(CFG_PEDAL_MIN_GAP, {8'b0, pmin});
        write_reg(CFG_PEDAL_TIMEOUT, ptmo);
        write_reg(CFG_WHEEL_MIN_GAP, {8'b0, wmin});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (pending_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mostly time moving forward, with spacing probes at the gap and timeout edges
    task automatic queue_random(input int n);
        int         made;
        int         r;
        logic [1:0] req;
        logic       chan;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 15) begin
                chan = 1'($urandom_range(1));
                req = chan ? REQ_WHEEL : REQ_PEDAL;
                offer(req, stamp);
                stamp = stamp + (chan ? cfg.wheel_min_gap : cfg.pedal_min_gap)
                        + $urandom_range(2) - 1;
                offer(req, stamp);
                stamp = stamp + (chan ? cfg.wheel_timeout : cfg.pedal_timeout)
                        + $urandom_range(2) - 1;
                offer(REQ_TICK, stamp);
                made += 3;
            end else begin
                r = $urandom_range(99);
                if (r < 40) stamp = stamp + $urandom_range(300);
                else if (r < 70) stamp = stamp + $urandom_range(3000);
                else if (r < 82) stamp = stamp + $urandom_range(70000);
                else if (r >= 90 && r < 96) stamp = stamp + $urandom_range(140000, 65000);
                else if (r >= 96) stamp = $urandom();
                r = $urandom_range(99);
                if (r < 38) req = REQ_PEDAL;
                else if (r < 68) req = REQ_WHEEL;
                else if (r < 97) req = REQ_TICK;
                else req = REQ_SPARE;
                offer(req, stamp);
                if (req != REQ_SPARE) made++;
            end
        end
    endtask

    task automatic run_phase(input logic [GAP_W-1:0] pmin, input logic [GAP_W-1:0] wmin,
                             input logic [TMO_W-1:0] ptmo, input logic [TMO_W-1:0] wtmo,
                             input logic [TIME_W-1:0] start, input int n);
        set_limits(pmin, wmin, ptmo, wtmo);
        stamp = start;
        queue_random(n);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: early pulses, exact gap, wrap of the timestamp, spare kind
        offer(REQ_PEDAL, 32'd10);
        offer(REQ_TICK, 32'd20);
        offer(REQ_PEDAL, 32'd64);
        offer(REQ_PEDAL, 32'd127);
        offer(REQ_PEDAL, 32'd300);
        offer(REQ_WHEEL, 32'd99);
        offer(REQ_WHEEL, 32'd100);
        offer(REQ_WHEEL, 32'd250);
        offer(REQ_TICK, 32'd400);
        offer(REQ_TICK, 32'd800);
        offer(REQ_SPARE, 32'hFFFF_FFFF);
        offer(REQ_PEDAL, 32'hFFFF_FFF0);
        offer(REQ_WHEEL, 32'hFFFF_FFFF);
        offer(REQ_PEDAL, 32'h0000_0020);
        offer(REQ_PEDAL, 32'h0000_0040);
        offer(REQ_TICK, 32'h0000_0050);
        offer(REQ_TICK, 32'hFFFF_FFFF);
        offer(REQ_PEDAL, 32'h8000_0000);
        offer(REQ_TICK, 32'h8000_0001);
        offer(REQ_TICK, 32'h8000_01F4);
        offer(REQ_WHEEL, 32'h8000_0BB8);
        offer(REQ_TICK, 32'h8000_1770);
        drain();

        run_phase(8'd0, 8'd0, 16'hFFFF, 16'hFFFF, $urandom(), 230);
        hold_go = 1'b1;
        run_phase(8'd255, 8'd255, 16'd0, 16'd0, $urandom(), 230);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(4000)), 16'($urandom_range(6000)), 32'hFFFF_F000, 230);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), $urandom(), 230);
        run_phase(8'd255, 8'd0, 16'd1, 16'hFFFF, $urandom(), 230);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(2000)), 16'($urandom_range(4000)), $urandom(), 230);
        run_phase(RST_PEDAL_MIN_GAP, RST_WHEEL_MIN_GAP, RST_PEDAL_TIMEOUT,
                  RST_WHEEL_TIMEOUT, $urandom(), 230);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(3000)), 16'($urandom_range(3000)), $urandom(), 230);

        // back to back with no idling on either side
        calm = 1'b1;
        set_limits(8'd0, 8'd0, 16'hFFFF, 16'hFFFF);
        repeat (SAT_LOOPS) begin
            offer(REQ_PEDAL, 32'h1000_0000);
            offer(REQ_WHEEL, 32'h1000_0000);
            offer(REQ_TICK, 32'h1000_0000);
        end
        drain();

        if (fails == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: pulse_period_activity_monitor_unit.f
src/ppam_pkg.sv
src/ppam_cfg_regs.sv
src/ppam_chan.sv
src/pulse_period_activity_monitor_unit.sv
tb/sv/tb_top.sv
